// ===== hw/rtl/k_nearest_max_heap_macros.svh =====
// ----------------------------------------------------------------------------
// k_nearest_max_heap_macros.svh
// Assertion macros used by the k-nearest selector RTL.
// ----------------------------------------------------------------------------
`ifndef K_NEAREST_MAX_HEAP_MACROS_SVH
`define K_NEAREST_MAX_HEAP_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define KNMH_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define KNMH_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define KNMH_ASSERT(lbl, clk, rstn, prop, msg)
`define KNMH_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

// ===== hw/rtl/knmh_pkg.sv =====
// ----------------------------------------------------------------------------
// knmh_pkg
// Types, constants and the microcode program of the k-nearest selector.
// ----------------------------------------------------------------------------
package knmh_pkg;

    localparam int K_MAX   = 64;
    localparam int IDX_W   = $clog2(K_MAX);
    localparam int CNT_W   = $clog2(K_MAX + 1);
    localparam int CHILD_W = IDX_W + 2;
    localparam int KCFG_W  = 7;
    localparam int ID_W    = 32;
    localparam int DIST_W  = 32;
    localparam int OP_W    = 2;
    localparam int ENTRY_W = ID_W + DIST_W;
    localparam int STEP_W  = 5;

    localparam logic [KCFG_W-1:0] K_RESET = KCFG_W'(64);

    localparam logic [OP_W-1:0] OPC_CLEAR  = OP_W'(0);
    localparam logic [OP_W-1:0] OPC_INSERT = OP_W'(1);
    localparam logic [OP_W-1:0] OPC_DRAIN  = OP_W'(2);

    // Datapath operation of one microcode step.
    typedef enum logic [3:0] {
        U_NOP,
        U_LATCH,
        U_EMIT_STATUS,
        U_CLEAR,
        U_APPEND,
        U_HEAPIFY_INIT,
        U_ROOT_READ,
        U_LOAD_ROOT,
        U_LOAD_NEW,
        U_READ_CHILDREN,
        U_MOVE_UP,
        U_PLACE,
        U_DRAIN_INIT,
        U_DRAIN_READ,
        U_EMIT_ENTRY
    } t_uop;

    // Jump condition of one microcode step.
    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NO_START,
        C_OP_INSERT,
        C_OP_DRAIN,
        C_OP_CLEAR,
        C_HELD_FULL,
        C_HELD_NOT_FULL,
        C_ROOT_ZERO,
        C_NO_CHILD,
        C_CHILD_NOT_GT,
        C_HEAPIFY,
        C_HELD_EMPTY,
        C_DRAIN_MORE
    } t_cond;

    typedef struct packed {
        t_uop              uop;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    // Status flags from the datapath that the jump conditions test.
    typedef struct packed {
        logic no_start;
        logic op_insert;
        logic op_drain;
        logic op_clear;
        logic held_full;
        logic root_zero;
        logic no_child;
        logic child_not_gt;
        logic heapify;
        logic held_empty;
        logic drain_more;
    } t_flags;

    // Program step addresses.
    localparam logic [STEP_W-1:0] S_IDLE       = STEP_W'(0);
    localparam logic [STEP_W-1:0] S_DISP       = STEP_W'(1);
    localparam logic [STEP_W-1:0] S_DISP_DRN   = STEP_W'(2);
    localparam logic [STEP_W-1:0] S_DISP_CLR   = STEP_W'(3);
    localparam logic [STEP_W-1:0] S_UNUSED_OP  = STEP_W'(4);
    localparam logic [STEP_W-1:0] S_CLR        = STEP_W'(5);
    localparam logic [STEP_W-1:0] S_STAT       = STEP_W'(6);
    localparam logic [STEP_W-1:0] S_INS        = STEP_W'(7);
    localparam logic [STEP_W-1:0] S_APPEND     = STEP_W'(8);
    localparam logic [STEP_W-1:0] S_FILL_CHECK = STEP_W'(9);
    localparam logic [STEP_W-1:0] S_HINIT      = STEP_W'(10);
    localparam logic [STEP_W-1:0] S_HLOOP      = STEP_W'(11);
    localparam logic [STEP_W-1:0] S_ROOT_READ  = STEP_W'(12);
    localparam logic [STEP_W-1:0] S_ROOT_LOAD  = STEP_W'(13);
    localparam logic [STEP_W-1:0] S_REPL       = STEP_W'(14);
    localparam logic [STEP_W-1:0] S_SIFT       = STEP_W'(15);
    localparam logic [STEP_W-1:0] S_COMPARE    = STEP_W'(16);
    localparam logic [STEP_W-1:0] S_MOVE       = STEP_W'(17);
    localparam logic [STEP_W-1:0] S_PLACE      = STEP_W'(18);
    localparam logic [STEP_W-1:0] S_SIFT_DONE  = STEP_W'(19);
    localparam logic [STEP_W-1:0] S_DRN        = STEP_W'(20);
    localparam logic [STEP_W-1:0] S_DLOOP      = STEP_W'(21);
    localparam logic [STEP_W-1:0] S_DEMIT      = STEP_W'(22);
    localparam logic [STEP_W-1:0] S_DDONE      = STEP_W'(23);

    function automatic t_uword uw(input t_uop uop, input t_cond cond,
                                  input logic [STEP_W-1:0] target);
        t_uword w;
        w.uop    = uop;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // The control store. A step jumps to its target when its condition
    // holds and otherwise goes on to the next address.
    function automatic t_uword ucode_word(input logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            S_IDLE:       w = uw(U_LATCH,         C_NO_START,      S_IDLE);
            S_DISP:       w = uw(U_NOP,           C_OP_INSERT,     S_INS);
            S_DISP_DRN:   w = uw(U_NOP,           C_OP_DRAIN,      S_DRN);
            S_DISP_CLR:   w = uw(U_NOP,           C_OP_CLEAR,      S_CLR);
            S_UNUSED_OP:  w = uw(U_EMIT_STATUS,   C_ALWAYS,        S_IDLE);
            S_CLR:        w = uw(U_CLEAR,         C_ALWAYS,        S_STAT);
            S_STAT:       w = uw(U_EMIT_STATUS,   C_ALWAYS,        S_IDLE);
            S_INS:        w = uw(U_NOP,           C_HELD_FULL,     S_REPL);
            S_APPEND:     w = uw(U_APPEND,        C_ALWAYS,        S_FILL_CHECK);
            S_FILL_CHECK: w = uw(U_NOP,           C_HELD_NOT_FULL, S_STAT);
            S_HINIT:      w = uw(U_HEAPIFY_INIT,  C_ALWAYS,        S_HLOOP);
            S_HLOOP:      w = uw(U_NOP,           C_ROOT_ZERO,     S_STAT);
            S_ROOT_READ:  w = uw(U_ROOT_READ,     C_ALWAYS,        S_ROOT_LOAD);
            S_ROOT_LOAD:  w = uw(U_LOAD_ROOT,     C_ALWAYS,        S_SIFT);
            S_REPL:       w = uw(U_LOAD_NEW,      C_ALWAYS,        S_SIFT);
            S_SIFT:       w = uw(U_READ_CHILDREN, C_NO_CHILD,      S_PLACE);
            S_COMPARE:    w = uw(U_NOP,           C_CHILD_NOT_GT,  S_PLACE);
            S_MOVE:       w = uw(U_MOVE_UP,       C_ALWAYS,        S_SIFT);
            S_PLACE:      w = uw(U_PLACE,         C_HEAPIFY,       S_HLOOP);
            S_SIFT_DONE:  w = uw(U_NOP,           C_ALWAYS,        S_STAT);
            S_DRN:        w = uw(U_DRAIN_INIT,    C_HELD_EMPTY,    S_STAT);
            S_DLOOP:      w = uw(U_DRAIN_READ,    C_ALWAYS,        S_DEMIT);
            S_DEMIT:      w = uw(U_EMIT_ENTRY,    C_DRAIN_MORE,    S_DLOOP);
            S_DDONE:      w = uw(U_NOP,           C_ALWAYS,        S_IDLE);
            default:      w = uw(U_NOP,           C_ALWAYS,        S_IDLE);
        endcase
        return w;
    endfunction

    // A k of zero acts as one; values above the heap size saturate to it.
    function automatic logic [CNT_W-1:0] clamp_k(input logic [KCFG_W-1:0] k);
        logic [CNT_W-1:0] r;
        if (k == KCFG_W'(0)) begin
            r = CNT_W'(1);
        end else if (int'(k) > K_MAX) begin
            r = CNT_W'(K_MAX);
        end else begin
            r = CNT_W'(k);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/knmh_heap_ram.sv =====
// ----------------------------------------------------------------------------
// knmh_heap_ram
// One write port, two registered read ports.
// ----------------------------------------------------------------------------
module knmh_heap_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic                     i_re_b,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while a port is not enabled.
    always_ff @(posedge i_clk) begin
        if (i_re_a) begin
            o_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// ===== hw/rtl/knmh_useq.sv =====
// ----------------------------------------------------------------------------
// knmh_useq
// Step counter and control store with conditional jumps.
// ----------------------------------------------------------------------------
module knmh_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  knmh_pkg::t_flags i_flags,
    output knmh_pkg::t_uword o_uword,
    output logic            o_busy
);
    import knmh_pkg::*;

    logic [STEP_W-1:0] r_pc;
    logic [STEP_W-1:0] n_pc;
    logic              w_take;

    always_comb begin
        o_uword = ucode_word(r_pc);
    end

    always_comb begin
        unique case (o_uword.cond)
            C_ALWAYS:        w_take = 1'b1;
            C_NO_START:      w_take = i_flags.no_start;
            C_OP_INSERT:     w_take = i_flags.op_insert;
            C_OP_DRAIN:      w_take = i_flags.op_drain;
            C_OP_CLEAR:      w_take = i_flags.op_clear;
            C_HELD_FULL:     w_take = i_flags.held_full;
            C_HELD_NOT_FULL: w_take = !i_flags.held_full;
            C_ROOT_ZERO:     w_take = i_flags.root_zero;
            C_NO_CHILD:      w_take = i_flags.no_child;
            C_CHILD_NOT_GT:  w_take = i_flags.child_not_gt;
            C_HEAPIFY:       w_take = i_flags.heapify;
            C_HELD_EMPTY:    w_take = i_flags.held_empty;
            C_DRAIN_MORE:    w_take = i_flags.drain_more;
            default:         w_take = 1'b1;
        endcase
    end

    always_comb begin
        n_pc = w_take ? o_uword.target : r_pc + STEP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_busy = (r_pc != S_IDLE);

endmodule

// ===== hw/rtl/k_nearest_max_heap.sv =====
// ----------------------------------------------------------------------------
// k_nearest_max_heap
// An unused opcode, an empty drain, a clear or an insert answers with one status beat; a
// replacing insert first sifts the new entry down from the root, level by level, and the
// insert that fills the heap also builds it before its status beat.
// A drain of a non-empty heap gives one beat per held entry, one after another.
// Throughput: one item at a time, set by the microcode walk; results cannot be stalled.
// Reset (synchronous, active low): nothing held, k register 64, active k 64.
// ----------------------------------------------------------------------------
`include "k_nearest_max_heap_macros.svh"

module k_nearest_max_heap (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Command channel.
    input  logic                           start,
    output logic                           busy,
    input  logic [knmh_pkg::OP_W-1:0]      i_opcode,
    input  logic [knmh_pkg::ID_W-1:0]      i_cand_id,
    input  logic [knmh_pkg::DIST_W-1:0]    i_cand_dist_sq,
    // Configuration channel: the k register.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [knmh_pkg::KCFG_W-1:0]    i_cfg_data,
    // Result channel, one beat per strobe.
    output logic                           o_strobe,
    output logic [knmh_pkg::CNT_W-1:0]     o_held_count,
    output logic                           o_is_full,
    output logic [knmh_pkg::DIST_W-1:0]    o_max_dist_sq,
    output logic [knmh_pkg::ID_W-1:0]      o_entry_id,
    output logic [knmh_pkg::DIST_W-1:0]    o_entry_dist_sq,
    output logic                           o_entry_valid,
    output logic                           o_last
);
    import knmh_pkg::*;

    // The block is a plain datapath around one heap RAM, driven by a small
    // microcode program in knmh_useq. Each step issues one datapath
    // operation and may jump on a status flag.

    t_uword w_uw;
    t_flags w_flags;

    // Command registers, captured every idle cycle so that they hold the
    // accepted beat once the sequencer leaves the idle step.
    logic [OP_W-1:0]   r_op;
    logic [ID_W-1:0]   r_id;
    logic [DIST_W-1:0] r_dist;

    // Query state.
    logic [KCFG_W-1:0] r_klook;
    logic [CNT_W-1:0]  r_kact;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [DIST_W-1:0] r_top;

    // Sift-down state: the element being sifted is held in r_x while the
    // hole at r_i walks down the heap.
    logic [IDX_W-1:0]   r_i;
    logic [IDX_W-1:0]   n_i;
    logic [IDX_W-1:0]   r_root;
    logic [IDX_W-1:0]   n_root;
    logic [ENTRY_W-1:0] r_x;
    logic [ENTRY_W-1:0] n_x;
    logic               r_heapify;
    logic               n_heapify;
    logic [CNT_W-1:0]   r_j;
    logic [CNT_W-1:0]   n_j;

    // RAM ports.
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic               w_re_a;
    logic [IDX_W-1:0]   w_raddr_a;
    logic [ENTRY_W-1:0] w_rdata_a;
    logic               w_re_b;
    logic [IDX_W-1:0]   w_raddr_b;
    logic [ENTRY_W-1:0] w_rdata_b;

    // Child selection.
    logic [CHILD_W-1:0] w_left;
    logic [CHILD_W-1:0] w_right;
    logic [CHILD_W-1:0] w_kext;
    logic               w_right_ok;
    logic               w_pick_right;
    logic [ENTRY_W-1:0] w_child;
    logic [CHILD_W-1:0] w_child_idx;
    logic               w_full;

    // Result registers.
    logic               r_strobe;
    logic [CNT_W-1:0]   r_held_count;
    logic               r_is_full;
    logic [DIST_W-1:0]  r_max_dist_sq;
    logic [ID_W-1:0]    r_entry_id;
    logic [DIST_W-1:0]  r_entry_dist_sq;
    logic               r_entry_valid;
    logic               r_last;
    logic               n_strobe;
    logic               n_entry_valid;
    logic               n_last;
    logic [ID_W-1:0]    n_entry_id;
    logic [DIST_W-1:0]  n_entry_dist_sq;

    knmh_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uword (w_uw),
        .o_busy  (busy)
    );

    knmh_heap_ram #(
        .DEPTH (K_MAX),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re_a    (w_re_a),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rdata_a),
        .i_re_b    (w_re_b),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_rdata_b)
    );

    // The k register is written only between items, so it is open exactly
    // while the sequencer sits in its idle step.
    assign o_cfg_ready = !busy;

    // Children of the hole are 2i+1 and 2i+2. The right child wins only
    // when strictly farther, and the hole moves only when the chosen child
    // is strictly farther than the sifted element, as a binary max-heap does.
    assign w_left       = CHILD_W'({r_i, 1'b1});
    assign w_right      = w_left + CHILD_W'(1);
    assign w_kext       = CHILD_W'(r_kact);
    assign w_right_ok   = (w_right < w_kext);
    assign w_pick_right = w_right_ok
                          && (w_rdata_b[DIST_W-1:0] > w_rdata_a[DIST_W-1:0]);
    assign w_child      = w_pick_right ? w_rdata_b : w_rdata_a;
    assign w_child_idx  = w_pick_right ? w_right : w_left;
    assign w_full       = (r_cnt == r_kact);

    always_comb begin
        w_flags.no_start     = !start;
        w_flags.op_insert    = (r_op == OPC_INSERT);
        w_flags.op_drain     = (r_op == OPC_DRAIN);
        w_flags.op_clear     = (r_op == OPC_CLEAR);
        w_flags.held_full    = w_full;
        w_flags.root_zero    = (r_root == IDX_W'(0));
        w_flags.no_child     = (w_left >= w_kext);
        w_flags.child_not_gt = !(w_child[DIST_W-1:0] > r_x[DIST_W-1:0]);
        w_flags.heapify      = r_heapify;
        w_flags.held_empty   = (r_cnt == CNT_W'(0));
        w_flags.drain_more   = (r_j != r_cnt);
    end

    // Datapath decode of the current microcode operation.
    always_comb begin
        w_we            = 1'b0;
        w_waddr         = r_i;
        w_wdata         = r_x;
        w_re_a          = 1'b0;
        w_raddr_a       = r_j[IDX_W-1:0];
        w_re_b          = 1'b0;
        w_raddr_b       = w_right[IDX_W-1:0];
        n_cnt           = r_cnt;
        n_i             = r_i;
        n_root          = r_root;
        n_x             = r_x;
        n_heapify       = r_heapify;
        n_j             = r_j;
        n_strobe        = 1'b0;
        n_entry_valid   = 1'b0;
        n_last          = 1'b1;
        n_entry_id      = '0;
        n_entry_dist_sq = '0;
        unique case (w_uw.uop)
            U_APPEND: begin
                // Fill phase: the new pair goes to the end of the array.
                w_we    = 1'b1;
                w_waddr = r_cnt[IDX_W-1:0];
                w_wdata = {r_id, r_dist};
                n_cnt   = r_cnt + CNT_W'(1);
            end
            U_HEAPIFY_INIT: begin
                n_root    = IDX_W'(r_kact >> 1);
                n_heapify = 1'b1;
            end
            U_ROOT_READ: begin
                w_re_a    = 1'b1;
                w_raddr_a = r_root - IDX_W'(1);
                n_root    = r_root - IDX_W'(1);
                n_i       = r_root - IDX_W'(1);
            end
            U_LOAD_ROOT: begin
                n_x = w_rdata_a;
            end
            U_LOAD_NEW: begin
                // The new candidate takes the place of the farthest entry.
                n_x       = {r_id, r_dist};
                n_i       = IDX_W'(0);
                n_heapify = 1'b0;
            end
            U_READ_CHILDREN: begin
                w_re_a    = 1'b1;
                w_raddr_a = w_left[IDX_W-1:0];
                w_re_b    = 1'b1;
                w_raddr_b = w_right[IDX_W-1:0];
            end
            U_MOVE_UP: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = w_child;
                n_i     = w_child_idx[IDX_W-1:0];
            end
            U_PLACE: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = r_x;
            end
            U_DRAIN_INIT: begin
                n_j = CNT_W'(0);
            end
            U_DRAIN_READ: begin
                w_re_a    = 1'b1;
                w_raddr_a = r_j[IDX_W-1:0];
                n_j       = r_j + CNT_W'(1);
            end
            U_EMIT_STATUS: begin
                n_strobe = 1'b1;
            end
            U_EMIT_ENTRY: begin
                n_strobe        = 1'b1;
                n_entry_valid   = 1'b1;
                n_last          = (r_j == r_cnt);
                n_entry_id      = w_rdata_a[ENTRY_W-1:DIST_W];
                n_entry_dist_sq = w_rdata_a[DIST_W-1:0];
            end
            default: begin
                // Steps that only test a flag, capture the command or clear
                // the query leave the sift state alone.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_uw.uop == U_LATCH) begin
            r_op   <= i_opcode;
            r_id   <= i_cand_id;
            r_dist <= i_cand_dist_sq;
        end
        r_i    <= n_i;
        r_root <= n_root;
        r_x    <= n_x;
        r_j    <= n_j;
        // Shadow of the heap top, kept by watching writes to entry zero.
        if (w_we && (w_waddr == IDX_W'(0))) begin
            r_top <= w_wdata[DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_klook   <= K_RESET;
            r_kact    <= clamp_k(K_RESET);
            r_cnt     <= CNT_W'(0);
            r_heapify <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_klook <= i_cfg_data;
            end
            r_heapify <= n_heapify;
            if (w_uw.uop == U_CLEAR) begin
                // A new query: drop everything held and take the new k.
                r_cnt  <= CNT_W'(0);
                r_kact <= clamp_k(r_klook);
            end else begin
                r_cnt <= n_cnt;
            end
        end
    end

    // Result beat. Status fields reflect the state after the item's update;
    // the farthest distance reads as zero until the heap is full.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe      <= 1'b0;
            r_entry_valid <= 1'b0;
        end else begin
            r_strobe      <= n_strobe;
            r_entry_valid <= n_entry_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_strobe) begin
            r_held_count    <= r_cnt;
            r_is_full       <= w_full;
            r_max_dist_sq   <= w_full ? r_top : DIST_W'(0);
            r_entry_id      <= n_entry_id;
            r_entry_dist_sq <= n_entry_dist_sq;
            r_last          <= n_last;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_held_count    = r_held_count;
    assign o_is_full       = r_is_full;
    assign o_max_dist_sq   = r_max_dist_sq;
    assign o_entry_id      = r_entry_id;
    assign o_entry_dist_sq = r_entry_dist_sq;
    assign o_entry_valid   = r_entry_valid;
    assign o_last          = r_last;

    `KNMH_ASSERT(a_strobe_while_busy, i_clk, i_rst_n, o_strobe |-> $past(busy), "result beat without an item in work")
    `KNMH_ASSERT(a_start_goes_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "accepted item did not start the sequencer")
    `KNMH_ASSERT(a_entry_has_strobe, i_clk, i_rst_n, o_entry_valid |-> o_strobe, "entry flag outside a result beat")
    `KNMH_NEVER(a_count_over_k, i_clk, i_rst_n, r_cnt > r_kact, "held count exceeds active k")
    `KNMH_NEVER(a_k_out_of_range, i_clk, i_rst_n, (r_kact == CNT_W'(0)) || (r_kact > CNT_W'(K_MAX)), "active k out of range")

endmodule

// ===== test/k_nearest_checker.sv =====
// ----------------------------------------------------------------------------
// k_nearest_checker
// Watches the command, k register and result channels of the k-nearest
// selector. It keeps its own copy of the bounded max-heap, predicts the
// result beats of every accepted command and compares them as they arrive.
// The entries of a drain are matched as a set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module k_nearest_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic [knmh_pkg::OP_W-1:0]      i_opcode,
    input  logic [knmh_pkg::ID_W-1:0]      i_cand_id,
    input  logic [knmh_pkg::DIST_W-1:0]    i_cand_dist_sq,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [knmh_pkg::KCFG_W-1:0]    i_cfg_data,
    input  logic                           i_strobe,
    input  logic [knmh_pkg::CNT_W-1:0]     i_held_count,
    input  logic                           i_is_full,
    input  logic [knmh_pkg::DIST_W-1:0]    i_max_dist_sq,
    input  logic [knmh_pkg::ID_W-1:0]      i_entry_id,
    input  logic [knmh_pkg::DIST_W-1:0]    i_entry_dist_sq,
    input  logic                           i_entry_valid,
    input  logic                           i_last,
    output int                             o_fail_count,
    output int                             o_pending
);
    import knmh_pkg::*;

    typedef struct {
        logic [CNT_W-1:0]  held;
        logic              full;
        logic [DIST_W-1:0] top_dist;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] entry_dist;
        logic              valid;
        logic              last;
        int                drain_tag;
    } t_result_beat;

    // Shadow of the heap RAM and the counters.
    logic [ID_W-1:0]   slot_id   [K_MAX];
    logic [DIST_W-1:0] slot_dist [K_MAX];
    logic [CNT_W-1:0]  held_now;
    logic [KCFG_W-1:0] k_reg;
    logic [CNT_W-1:0]  k_live;

    t_result_beat expected_beats [$];
    int           drain_seq   = 0;
    int           fail_total  = 0;
    int           pending_now = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_now;

    function automatic logic [CNT_W-1:0] effective_k(input logic [KCFG_W-1:0] raw);
        logic [CNT_W-1:0] k;
        if (raw == '0) begin
            k = CNT_W'(1);
        end else if (int'(raw) > K_MAX) begin
            k = CNT_W'(K_MAX);
        end else begin
            k = CNT_W'(raw);
        end
        return k;
    endfunction

    // Swap-based sift-down of one slot within the first n slots.
    function automatic void sink_slot(input int unsigned at, input int unsigned n);
        int unsigned       pos;
        int unsigned       kid;
        logic [ID_W-1:0]   tmp_id;
        logic [DIST_W-1:0] tmp_dist;
        pos = at;
        while (2 * pos + 1 < n) begin
            kid = 2 * pos + 1;
            if (kid + 1 < n && slot_dist[kid + 1] > slot_dist[kid]) kid = kid + 1;
            if (slot_dist[kid] > slot_dist[pos]) begin
                tmp_id         = slot_id[kid];
                tmp_dist       = slot_dist[kid];
                slot_id[kid]   = slot_id[pos];
                slot_dist[kid] = slot_dist[pos];
                slot_id[pos]   = tmp_id;
                slot_dist[pos] = tmp_dist;
                pos = kid;
            end else begin
                break;
            end
        end
    endfunction

    function automatic void push_beat(input logic valid, input logic [ID_W-1:0] id,
                                      input logic [DIST_W-1:0] ent_dist, input logic last,
                                      input int tag);
        t_result_beat b;
        b.held       = held_now;
        b.full       = (held_now == k_live);
        b.top_dist   = (b.full && held_now != '0) ? slot_dist[0] : '0;
        b.id         = valid ? id : '0;
        b.entry_dist = valid ? ent_dist : '0;
        b.valid      = valid;
        b.last       = last;
        b.drain_tag  = tag;
        expected_beats.push_back(b);
    endfunction

    function automatic void apply_command(input logic [OP_W-1:0] op,
                                          input logic [ID_W-1:0] id,
                                          input logic [DIST_W-1:0] cand_dist);
        int unsigned n;
        case (op)
            OPC_CLEAR: begin
                held_now = '0;
                k_live   = effective_k(k_reg);
                push_beat(1'b0, '0, '0, 1'b1, 0);
            end
            OPC_INSERT: begin
                if (held_now < k_live) begin
                    slot_id[held_now]   = id;
                    slot_dist[held_now] = cand_dist;
                    held_now = held_now + 1'b1;
                    if (held_now == k_live) begin
                        for (int i = int'(k_live) / 2 - 1; i >= 0; i--) begin
                            sink_slot(i, k_live);
                        end
                    end
                end else begin
                    slot_id[0]   = id;
                    slot_dist[0] = cand_dist;
                    sink_slot(0, k_live);
                end
                push_beat(1'b0, '0, '0, 1'b1, 0);
            end
            OPC_DRAIN: begin
                n = held_now;
                if (n == 0) begin
                    push_beat(1'b0, '0, '0, 1'b1, 0);
                end else begin
                    drain_seq++;
                    for (int unsigned i = 0; i < n; i++) begin
                        push_beat(1'b1, slot_id[i], slot_dist[i], i + 1 == n, drain_seq);
                    end
                end
            end
            default: begin
                push_beat(1'b0, '0, '0, 1'b1, 0);
            end
        endcase
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_total++;
        end
    endtask

    task automatic check_beat();
        t_result_beat want;
        int           pick;
        int           span;
        int           tag0;
        bit           found;
        if (expected_beats.size() == 0) begin
            $error("result beat arrived with nothing expected");
            fail_total++;
        end else begin
            pick = 0;
            want = expected_beats[0];
            if (want.valid) begin
                // Drain entries come in any order: look for this one among the
                // entries of the same drain that are still outstanding.
                tag0  = want.drain_tag;
                span  = 0;
                found = 1'b0;
                while (span < expected_beats.size() &&
                       expected_beats[span].drain_tag == tag0) begin
                    if (!found && expected_beats[span].id === i_entry_id &&
                        expected_beats[span].entry_dist === i_entry_dist_sq) begin
                        pick  = span;
                        found = 1'b1;
                    end
                    span++;
                end
                want      = expected_beats[pick];
                want.last = (span == 1);
            end
            expected_beats.delete(pick);
            compare_field("held_count",    want.held,       i_held_count);
            compare_field("is_full",       want.full,       i_is_full);
            compare_field("max_dist_sq",   want.top_dist,   i_max_dist_sq);
            compare_field("entry_id",      want.id,         i_entry_id);
            compare_field("entry_dist_sq", want.entry_dist, i_entry_dist_sq);
            compare_field("entry_valid",   want.valid,      i_entry_valid);
            compare_field("last",          want.last,       i_last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_now = '0;
            k_reg    = K_RESET;
            k_live   = effective_k(K_RESET);
            expected_beats.delete();
        end else begin
            if (i_strobe) check_beat();
            if (i_cfg_valid && i_cfg_ready) k_reg = i_cfg_data;
            if (i_start && !i_busy) apply_command(i_opcode, i_cand_id, i_cand_dist_sq);
        end
        pending_now = expected_beats.size();
    end

endmodule

// ===== test/tb_k_nearest_max_heap.sv =====
// ----------------------------------------------------------------------------
// tb_k_nearest_max_heap
// Drives clear, insert, drain and unused-opcode commands into the k-nearest
// selector under a series of k settings, with random sender gaps, and lets
// the checker beside the block predict and compare every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_k_nearest_max_heap;
    import knmh_pkg::*;

    // Opcode 3 is not decoded by the block; it must answer with a status beat.
    localparam logic [OP_W-1:0] OPC_SPARE = OP_W'(3);

    // Ways of choosing candidate distances within one query.
    localparam int DIST_WIDE = 0;   // anything in the 32-bit range
    localparam int DIST_TIED = 1;   // a handful of values, so ties are common
    localparam int DIST_EDGE = 2;   // mostly the two ends of the range

    // Counted items over the whole run, directed part included.
    localparam int ITEM_GOAL    = 370;
    localparam int QUIET_TAIL   = 50;
    // The slowest beat-free stretch is the heap build of k = 64 plus a
    // sender gap. The limit is taken well above that.
    localparam int STALL_LIMIT  = 4000;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     i_opcode;
    logic [ID_W-1:0]     i_cand_id;
    logic [DIST_W-1:0]   i_cand_dist_sq;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [KCFG_W-1:0]   i_cfg_data;
    logic                o_strobe;
    logic [CNT_W-1:0]    o_held_count;
    logic                o_is_full;
    logic [DIST_W-1:0]   o_max_dist_sq;
    logic [ID_W-1:0]     o_entry_id;
    logic [DIST_W-1:0]   o_entry_dist_sq;
    logic                o_entry_valid;
    logic                o_last;

    int fail_count;
    int pending;

    // Stimulus bookkeeping, used for the gaps and the closing summary.
    int  counted_items = 0;
    int  n_clear       = 0;
    int  n_insert      = 0;
    int  n_drain       = 0;
    int  n_spare       = 0;
    int  k_writes      = 0;
    int  phases        = 0;
    bit  gaps_on       = 1'b1;
    bit  quiet         = 1'b0;

    k_nearest_max_heap DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_cand_id       (i_cand_id),
        .i_cand_dist_sq  (i_cand_dist_sq),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_held_count    (o_held_count),
        .o_is_full       (o_is_full),
        .o_max_dist_sq   (o_max_dist_sq),
        .o_entry_id      (o_entry_id),
        .o_entry_dist_sq (o_entry_dist_sq),
        .o_entry_valid   (o_entry_valid),
        .o_last          (o_last)
    );

    k_nearest_checker u_heap_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_opcode        (i_opcode),
        .i_cand_id       (i_cand_id),
        .i_cand_dist_sq  (i_cand_dist_sq),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_strobe        (o_strobe),
        .i_held_count    (o_held_count),
        .i_is_full       (o_is_full),
        .i_max_dist_sq   (o_max_dist_sq),
        .i_entry_id      (o_entry_id),
        .i_entry_dist_sq (o_entry_dist_sq),
        .i_entry_valid   (o_entry_valid),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: counts the cycles in which no beat of any channel is accepted,
    // starts over at each accepted beat, and fails the run at the stall limit.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("k_nearest_max_heap verification failed");
        $finish;
    end

    // Keeps start low until the block is free again and then for a further gap
    // given by n, so that every gap shows up as idle time at the input.
    task automatic idle_gap(input int n);
        @(negedge i_clk);
        start = 1'b0;
        while (busy) @(negedge i_clk);
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Presents one command beat and holds it until the block takes it. The
    // inputs change only at falling edges; start stays high across
    // back-to-back commands.
    task automatic send_command(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                input logic [DIST_W-1:0] cand_dist);
        @(negedge i_clk);
        start          = 1'b1;
        i_opcode       = op;
        i_cand_id      = id;
        i_cand_dist_sq = cand_dist;
        do @(posedge i_clk); while (busy);
        case (op)
            OPC_CLEAR:  n_clear++;
            OPC_INSERT: n_insert++;
            OPC_DRAIN:  n_drain++;
            default:    n_spare++;
        endcase
        // Unused-opcode beats do not count toward the item total.
        if (op != OPC_SPARE) counted_items++;
        if (gaps_on && !quiet && $urandom_range(0, 2) == 0) begin
            idle_gap($urandom_range(1, 10));
        end
    endtask

    // Holds the sender off until every predicted result has come back and
    // the block has gone idle.
    task automatic drain_outstanding();
        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0 || busy) @(negedge i_clk);
    endtask

    // Writes the k register. It is only touched while the block is idle.
    task automatic write_k(input logic [KCFG_W-1:0] value);
        drain_outstanding();
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data  = KCFG_W'($urandom);
        k_writes++;
    endtask

    function automatic logic [DIST_W-1:0] pick_dist(input int mode);
        logic [DIST_W-1:0] d;
        case (mode)
            DIST_TIED: d = DIST_W'($urandom_range(0, 7));
            DIST_EDGE: begin
                case ($urandom_range(0, 2))
                    0:       d = '0;
                    1:       d = '1;
                    default: d = $urandom;
                endcase
            end
            default:   d = $urandom;
        endcase
        return d;
    endfunction

    initial begin
        logic [KCFG_W-1:0] k_set;
        int                k_eff;
        int                n_ins;
        int                dist_mode;
        int                roll;
        int                random_goal;

        // Every input is known from time zero; reset is released at a falling edge.
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_opcode       = OPC_CLEAR;
        i_cand_id      = '0;
        i_cand_dist_sq = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // ---------------- Directed part ----------------
        // Out of reset k is 64 and nothing is held: a drain answers with a
        // single status beat, and so does the unused opcode.
        send_command(OPC_DRAIN, '0, '0);
        send_command(OPC_SPARE, '1, '1);
        // Field extremes while the fill array is far from full.
        send_command(OPC_INSERT, '1, '1);
        send_command(OPC_INSERT, '0, '0);
        send_command(OPC_DRAIN, '0, '0);
        // Let everything come home once before going on.
        drain_outstanding();
        // A k of zero is written, but it only takes hold at the next clear,
        // so this insert still sees k = 64.
        write_k('0);
        send_command(OPC_INSERT, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
        // The clear latches k = 0, which behaves as k = 1: each insert fills
        // the single slot or replaces it.
        send_command(OPC_CLEAR, '0, '0);
        send_command(OPC_INSERT, '0, '0);
        send_command(OPC_INSERT, '1, '1);
        send_command(OPC_DRAIN, '0, '0);
        // A k above the heap size saturates to 64.
        write_k('1);
        send_command(OPC_CLEAR, '0, '0);
        send_command(OPC_DRAIN, '0, '0);
        // Small heap with equal distances: the heap shape picks which of the
        // tied entries is replaced.
        write_k(KCFG_W'(3));
        send_command(OPC_CLEAR, '0, '0);
        send_command(OPC_INSERT, 32'd1, 32'd100);
        send_command(OPC_INSERT, 32'd2, 32'd100);
        send_command(OPC_INSERT, 32'd3, 32'd100);
        send_command(OPC_INSERT, 32'd4, 32'd100);
        send_command(OPC_INSERT, 32'd5, 32'd50);
        send_command(OPC_INSERT, 32'd6, '1);
        send_command(OPC_SPARE, $urandom, $urandom);
        send_command(OPC_DRAIN, '0, '0);

        // ---------------- Random part ----------------
        // Each phase is one query: set k, clear, a run of inserts with
        // random content, and a drain. Noise beats, early drains and
        // restarting clears are mixed in.
        random_goal = ITEM_GOAL;
        while (counted_items < random_goal) begin
            case (phases)
                0:       k_set = KCFG_W'(64);
                1:       k_set = KCFG_W'(1);
                2:       k_set = '0;
                3:       k_set = '1;
                default: begin
                    roll = $urandom_range(0, 9);
                    if (roll < 7) begin
                        k_set = KCFG_W'($urandom_range(1, 12));
                    end else if (roll == 7) begin
                        k_set = KCFG_W'($urandom_range(13, 24));
                    end else if (roll == 8) begin
                        k_set = KCFG_W'($urandom_range(65, 127));
                    end else begin
                        k_set = '0;
                    end
                end
            endcase
            k_eff = (k_set == '0) ? 1 : (int'(k_set) > K_MAX) ? K_MAX : int'(k_set);

            // Saturated settings are only partly filled; the big heap gets
            // filled once with a few replacements, the small ones are pushed
            // well past full most of the time.
            if (int'(k_set) > K_MAX) begin
                n_ins = $urandom_range(3, 14);
            end else if (k_eff >= 25) begin
                n_ins = k_eff + $urandom_range(2, 10);
            end else if ($urandom_range(0, 4) == 0) begin
                n_ins = $urandom_range(0, k_eff);
            end else begin
                n_ins = k_eff + $urandom_range(1, 2 * k_eff + 4);
            end
            dist_mode = $urandom_range(DIST_WIDE, DIST_EDGE);
            gaps_on   = ($urandom_range(0, 3) != 0);

            write_k(k_set);
            send_command(OPC_CLEAR, $urandom, $urandom);
            for (int i = 0; i < n_ins && counted_items < random_goal; i++) begin
                quiet = (counted_items >= random_goal - QUIET_TAIL);
                roll  = $urandom_range(0, 99);
                if (roll < 6) begin
                    send_command(OPC_DRAIN, $urandom, $urandom);
                end else if (roll < 10) begin
                    send_command(OPC_SPARE, $urandom, $urandom);
                end else if (roll < 12) begin
                    // Restart the query in the middle of the stream.
                    send_command(OPC_CLEAR, $urandom, $urandom);
                end
                if (roll >= 96) drain_outstanding();
                send_command(OPC_INSERT, $urandom, pick_dist(dist_mode));
            end
            send_command(OPC_DRAIN, $urandom, $urandom);
            if ($urandom_range(0, 3) == 0) begin
                send_command(OPC_SPARE, $urandom, $urandom);
                send_command(OPC_DRAIN, $urandom, $urandom);
            end
            phases++;
        end

        // ---------------- Wind-down ----------------
        // Wait for every predicted beat and for the block to go idle, then a
        // further margin in case something unexpected trails behind.
        drain_outstanding();
        repeat (40) @(negedge i_clk);

        if (pending != 0) $error("%0d expected result beats never arrived", pending);
        $display("Covered %0d clears, %0d inserts, %0d drains and %0d unused-opcode beats",
                 n_clear, n_insert, n_drain, n_spare);
        $display("across %0d random queries and %0d k writes, including k = 0, 1, 64, 127",
                 phases, k_writes);
        if (fail_count == 0 && pending == 0) begin
            $display("k_nearest_max_heap verification clean");
        end else begin
            $display("k_nearest_max_heap verification failed");
        end
        $finish;
    end

endmodule
